// ===== rtl/tdpt_pkg.sv =====
// tdpt_pkg: widths, constants and shared types for the trial division prime test
// no dependencies; imported by tdpt_divider, trial_division_prime_test and tb_top
package tdpt_pkg;

   // width of the number under test
   localparam int NUMBER_WIDTH = 32;

   // trial divisors reach the ceiling of the square root, plus one spare bit
   localparam int DIV_W = (NUMBER_WIDTH + 1) / 2 + 1;

   // bit counter of the divider, one quotient bit per cycle
   localparam int CNT_W = $clog2(NUMBER_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUMBER_WIDTH - 1);

   // smallest prime, also the first trial divisor
   localparam logic [NUMBER_WIDTH-1:0] MIN_PRIME     = NUMBER_WIDTH'(2);
   localparam logic [DIV_W-1:0]        FIRST_DIVISOR = DIV_W'(2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIVIDE,
      ST_FINISH
   } tdpt_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/tdpt_divider.sv =====
// tdpt_divider: shared restoring divider, one quotient bit per clock
// depends on tdpt_pkg for widths and the status struct
module tdpt_divider import tdpt_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUMBER_WIDTH-1:0] dividend,
   input  logic [DIV_W-1:0]        divisor,
   output div_status_type          status,
   output logic [NUMBER_WIDTH-1:0] quotient,
   output logic [DIV_W-1:0]        remainder
);

   logic                    run_ff,  run_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [NUMBER_WIDTH-1:0] quo_ff,  quo_in;
   logic [DIV_W-1:0]        rem_ff,  rem_in;
   logic [DIV_W-1:0]        dvs_ff,  dvs_in;

   logic [DIV_W:0] shifted;
   logic [DIV_W:0] diff;
   logic           fits;

   // one restoring step
   assign shifted = {rem_ff, quo_ff[NUMBER_WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         run_in   = 1'b1;
         count_in = CNT_LAST;
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (run_ff) begin
         quo_in = {quo_ff[NUMBER_WIDTH-2:0], fits};
         rem_in = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         if (count_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

// ===== rtl/trial_division_prime_test.sv =====
// trial_division_prime_test: top level, sequencer around one shared divider
// depends on tdpt_pkg and tdpt_divider
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   req     | in        | req_valid/req_stall | req_number   (NUMBER_WIDTH)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_is_prime (1 bit)
//
// one item at a time: every trial divisor costs a start state and one full
// divide on the shared divider, so the time an item takes grows with the
// number of divisors tried
// zero and one go straight to the finish state without using the divider
// reset is synchronous and active high; it clears the sequencer and rsp_valid
// a stalled result sits in the output register while the next item is taken

module trial_division_prime_test import tdpt_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [NUMBER_WIDTH-1:0] req_number,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_is_prime
);

   tdpt_state_type state_ff, state_in;

   // held item and trial divisor
   logic [NUMBER_WIDTH-1:0] number_ff;
   logic [DIV_W-1:0]        divisor_ff;
   logic                    result_ff;

   // output register
   logic rsp_valid_ff;
   logic rsp_is_prime_ff;

   // divider side
   div_status_type          div_status;
   logic [NUMBER_WIDTH-1:0] div_quotient;
   logic [DIV_W-1:0]        div_remainder;
   logic                    div_start;

   // sequencer decodes
   logic take_req;
   logic load_rsp;
   logic trial_done;
   logic bound_passed;   // divisor exceeds the quotient: no factor left
   logic factor_found;

   tdpt_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (number_ff),
      .divisor   (divisor_ff),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // d <= n / d is checked against the same quotient that gives n % d
   assign bound_passed = {{(NUMBER_WIDTH-DIV_W){1'b0}}, divisor_ff} > div_quotient;
   assign factor_found = div_remainder == '0;
   assign trial_done   = (state_ff == ST_DIVIDE) && div_status.done;
   assign take_req     = req_valid && !req_stall;

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_START:  div_start = 1'b1;
         ST_DIVIDE: req_stall = 1'b1;
         ST_FINISH: load_rsp  = !rsp_valid_ff || !rsp_stall;
         default:   req_stall = 1'b1;
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_req) begin
               // zero and one skip the divider
               state_in = (req_number < MIN_PRIME) ? ST_FINISH : ST_START;
            end
         end
         ST_START: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (trial_done) begin
               state_in = (bound_passed || factor_found) ? ST_FINISH : ST_START;
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // held number, trial divisor and verdict
   always_ff @(posedge clock) begin
      if (take_req) begin
         number_ff  <= req_number;
         divisor_ff <= FIRST_DIVISOR;
         result_ff  <= 1'b0;
      end else if (trial_done) begin
         if (bound_passed) begin
            result_ff <= 1'b1;
         end else if (factor_found) begin
            result_ff <= 1'b0;
         end else begin
            divisor_ff <= divisor_ff + DIV_W'(1);
         end
      end
   end

   // output register, freed when the item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_is_prime_ff <= result_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for trial_division_prime_test
// depends on tdpt_pkg and the rtl of trial_division_prime_test; needs nothing else
// directed edge cases, then random numbers under three idling patterns
`timescale 1ns / 1ps

module tb_top;
   import tdpt_pkg::*;

   // worst accepted item: a random number needing MAX_RANDOM_TRIALS trial divisors,
   // or the largest directed prime, which has the longest search; the whole run
   // stays several times under CYCLE_LIMIT at worst
   localparam int unsigned CYCLE_LIMIT       = 4_000_000;
   localparam int unsigned MAX_RANDOM_TRIALS = 200;
   // two divides with their start states, plus margin, once nothing is outstanding
   localparam int unsigned DRAIN_CYCLES      = 2 * (NUMBER_WIDTH + 2) + 16;

   typedef struct {
      logic [NUMBER_WIDTH-1:0] number;
      logic                    is_prime;
   } prime_verdict_type;

   logic                    clock        = 1'b0;
   logic                    reset        = 1'b1;
   logic                    req_valid    = 1'b0;
   logic                    req_stall;
   logic [NUMBER_WIDTH-1:0] req_number   = '0;
   logic                    rsp_valid;
   logic                    rsp_stall    = 1'b0;
   logic                    rsp_is_prime;

   // verdicts of accepted items, oldest first
   prime_verdict_type verdict_q[$];
   prime_verdict_type oldest_verdict;

   int unsigned fail_count;
   int unsigned cycle_count;
   int unsigned items_sent;
   int unsigned primes_sent;
   int unsigned longest_search;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   trial_division_prime_test u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_number   (req_number),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_prime (rsp_is_prime)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // trial division at full width: divisors from 2 while d <= n / d, stop at
   // the first one that divides; 0 and 1 are not prime
   function automatic logic is_prime_by_trial(input logic [NUMBER_WIDTH-1:0] value,
                                              output int unsigned trials);
      logic [63:0] n;
      logic [63:0] d;
      logic        verdict;
      n       = 64'(value);
      d       = 64'd2;
      trials  = 0;
      verdict = 1'b1;
      if (n < 64'd2) begin
         verdict = 1'b0;
      end else begin
         while (verdict && d <= n / d) begin
            trials++;
            if (n % d == 64'd0) begin
               verdict = 1'b0;
            end else begin
               d++;
            end
         end
      end
      return verdict;
   endfunction

   // offer one number, with a random gap first, and record its verdict once taken
   // valid is only lowered when a gap is wanted, so back-to-back items keep it high
   task automatic send_number(input logic [NUMBER_WIDTH-1:0] value);
      int unsigned trials;
      logic        verdict;
      verdict = is_prime_by_trial(value, trials);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid  <= 1'b1;
      req_number <= value;
      // the item goes in at the first edge with stall low
      do @(posedge clock); while (req_stall);
      verdict_q.push_back('{number: value, is_prime: verdict});
      items_sent++;
      if (verdict) begin
         primes_sent++;
      end
      if (trials > longest_search) begin
         longest_search = trials;
      end
   endtask

   // zero and one skip the divider and must read not prime
   task automatic test_zero_and_one;
      send_number(NUMBER_WIDTH'(0));
      send_number(NUMBER_WIDTH'(1));
   endtask

   // two and three: no divisor passes the square bound; five tries one divisor
   task automatic test_smallest_primes;
      send_number(NUMBER_WIDTH'(2));
      send_number(NUMBER_WIDTH'(3));
      send_number(NUMBER_WIDTH'(5));
   endtask

   // prime squares: the only factor sits exactly on the square bound
   task automatic test_prime_squares;
      send_number(NUMBER_WIDTH'(4));
      send_number(NUMBER_WIDTH'(9));
      send_number(NUMBER_WIDTH'(25));
      send_number(NUMBER_WIDTH'(49));
      send_number(NUMBER_WIDTH'(121));
      send_number(NUMBER_WIDTH'(63001));
   endtask

   // longer searches that run all the way to the bound
   task automatic test_larger_primes;
      send_number(NUMBER_WIDTH'(65521));
      send_number(NUMBER_WIDTH'(65537));
      send_number(NUMBER_WIDTH'(1000003));
      send_number(NUMBER_WIDTH'(1048573));
   endtask

   // wide bit patterns, all composite with a small factor so they stay quick
   task automatic test_wide_patterns;
      send_number('1);
      send_number({{(NUMBER_WIDTH-1){1'b1}}, 1'b0});
      send_number(NUMBER_WIDTH'(1) << (NUMBER_WIDTH - 1));
      send_number({(NUMBER_WIDTH/2){2'b10}});
      send_number({(NUMBER_WIDTH/2){2'b01}});
      send_number(NUMBER_WIDTH'(64'd4294836225));
   endtask

   // random numbers of random bit length; ones whose search would be long are
   // drawn again so the run stays short, which still leaves plenty of primes
   task automatic test_random_values(input int unsigned count);
      logic [63:0]             raw;
      logic [NUMBER_WIDTH-1:0] value;
      int unsigned             width;
      int unsigned             trials;
      repeat (count) begin
         do begin
            width = $urandom_range(1, NUMBER_WIDTH);
            raw   = {$urandom, $urandom};
            value = NUMBER_WIDTH'(raw & ((64'd1 << width) - 64'd1));
            void'(is_prime_by_trial(value, trials));
         end while (trials > MAX_RANDOM_TRIALS);
         send_number(value);
      end
   endtask

   // receiver back-pressure, redrawn every clock
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // compare every taken result with the oldest outstanding verdict
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $error("rsp_is_prime with no item outstanding: actual %0b", rsp_is_prime);
            fail_count++;
         end else begin
            oldest_verdict = verdict_q.pop_front();
            if (rsp_is_prime !== oldest_verdict.is_prime) begin
               $error("rsp_is_prime mismatch for number %0d: expected %0b, actual %0b",
                      oldest_verdict.number, oldest_verdict.is_prime, rsp_is_prime);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still outstanding",
                  cycle_count, verdict_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      // sender light, receiver heavy for the directed part and the first random third
      send_idle_pct = 14;
      recv_idle_pct = 61;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_zero_and_one;
      test_smallest_primes;
      test_prime_squares;
      test_larger_primes;
      test_wide_patterns;
      test_random_values(27);

      // roles swapped
      send_idle_pct = 61;
      recv_idle_pct = 14;
      test_random_values(27);

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_values(26);

      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d numbers: %0d prime, %0d not prime", items_sent, primes_sent,
               items_sent - primes_sent);
      $display("longest search %0d trial divisors, %0d clocks in all",
               longest_search, cycle_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
